### hdl/dfr_pkg.sv
// Package with the shared types and constants of the segment packet deframer.
`default_nettype none

package dfr_pkg;

  localparam int MAX_DATAGRAM = 65535;
  localparam int BCNT_W       = $clog2(MAX_DATAGRAM + 1);

  localparam logic [7:0] OPCODE_FILE = 8'h46;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  localparam int FLEN_DIGITS  = 3;
  localparam int OLEN_DIGITS  = 5;
  localparam int SEQ_DIGITS   = 12;
  localparam int PSIZE_DIGITS = 22;
  localparam int TOTAL_DIGITS = 4;
  localparam int CUR_DIGITS   = 4;

  localparam int TRAIL_DEPTH = 5;
  localparam int FILL_W      = $clog2(TRAIL_DEPTH + 1);

  localparam int FIELD_W = 17;
  localparam int ACC_W   = 40;
  localparam int SEQ_W   = 40;
  localparam int SEG_W   = 14;
  localparam int SUM_W   = 16;
  localparam int PCNT_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_DLEN,
    PH_DSKIP,
    PH_FLEN,
    PH_FSKIP,
    PH_OLEN,
    PH_OSKIP,
    PH_SEQ,
    PH_PSIZE,
    PH_TOTAL,
    PH_CUR,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_SHORT    = 2'd2,
    ST_NOTFILE  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Work handed from the parser to the emitter for one accepted byte.
  typedef struct packed {
    logic                              has_payload;
    logic [7:0]                        pay_byte;
    logic                              has_summary;
    logic                              drop;
    logic                              too_short;
    logic [SEQ_W-1:0]                  seq;
    logic [SEG_W-1:0]                  total;
    logic [SEG_W-1:0]                  current;
    logic [PCNT_W-1:0]                 count;
    logic [SUM_W-1:0]                  sum;
    logic [TRAIL_DEPTH-1:0][7:0]       window;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        out_byte;
    logic [SEQ_W-1:0]  seq_number;
    logic [SEG_W-1:0]  total_segments;
    logic [SEG_W-1:0]  segment_index;
    logic [PCNT_W-1:0] payload_bytes;
    status_e           status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### hdl/dfr_if.sv
// Handshake interfaces for the byte input and the result output of the deframer.
`default_nettype none

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, data_byte, end_of_datagram, input ready);
  modport sink   (input valid, data_byte, end_of_datagram, output ready);
endinterface

interface dfr_out_if import dfr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        out_byte;
  logic [SEQ_W-1:0]  seq_number;
  logic [SEG_W-1:0]  total_segments;
  logic [SEG_W-1:0]  segment_index;
  logic [PCNT_W-1:0] payload_bytes;
  logic [1:0]        status;
  logic              last;

  modport source (output valid, kind, out_byte, seq_number, total_segments, segment_index,
                  payload_bytes, status, last, input ready);
  modport sink   (input valid, kind, out_byte, seq_number, total_segments, segment_index,
                  payload_bytes, status, last, output ready);
endinterface

`default_nettype wire

### hdl/dfr_front.sv
// Header parser: walks the datagram fields and turns each byte into emitter work.
`default_nettype none

module dfr_front import dfr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfr_in_if.sink     in_i,
  output logic       push_o,
  output cmd_t       push_cmd_o,
  input  wire logic  push_ready_i
);

  phase_e             phase_q, phase_d;
  logic [FIELD_W-1:0] fc_q, fc_d;
  logic [FIELD_W-1:0] skip_q, skip_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               stop_q, stop_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [SEG_W-1:0]   total_q, total_d;
  logic [SEG_W-1:0]   cur_q, cur_d;
  logic [7:0]         trail_q [TRAIL_DEPTH];
  logic [7:0]         trail_d [TRAIL_DEPTH];
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PCNT_W-1:0]  pcnt_q, pcnt_d;
  logic               drop_q, drop_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;

  logic               accept;
  logic               take;
  logic               eod;
  logic [7:0]         b;
  logic               is_digit;
  logic [ACC_W-1:0]   acc_dig;
  logic               stop_dig;
  logic [FIELD_W-1:0] fc_inc;
  logic               pay_valid;
  logic [7:0]         pay_byte;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;
  assign b          = in_i.data_byte;
  assign eod        = in_i.end_of_datagram;
  assign take       = accept && (bcnt_q < BCNT_W'(MAX_DATAGRAM));
  assign is_digit   = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  assign fc_inc     = fc_q + FIELD_W'(1);

  // One decimal step: acc * 10 + digit, frozen after the first non-digit.
  always_comb begin
    if (!stop_q && is_digit) begin
      acc_dig  = (acc_q << 3) + (acc_q << 1) + ACC_W'(b - ASCII_ZERO);
      stop_dig = 1'b0;
    end else begin
      acc_dig  = acc_q;
      stop_dig = 1'b1;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    fc_d      = fc_q;
    skip_d    = skip_q;
    acc_d     = acc_q;
    stop_d    = stop_q;
    seq_d     = seq_q;
    total_d   = total_q;
    cur_d     = cur_q;
    trail_d   = trail_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    pcnt_d    = pcnt_q;
    drop_d    = drop_q;
    bcnt_d    = bcnt_q;
    pay_valid = 1'b0;
    pay_byte  = trail_q[0];

    if (take) begin
      bcnt_d = bcnt_q + BCNT_W'(1);
      if (!drop_q) begin
        unique case (phase_q)
          PH_OPCODE: begin
            if (b == OPCODE_FILE) phase_d = PH_DLEN;
            else                  drop_d  = 1'b1;
          end
          PH_DLEN: begin
            fc_d = '0;
            if (b == 8'd0) begin
              phase_d = PH_FLEN;
              acc_d   = '0;
              stop_d  = 1'b0;
            end else begin
              phase_d = PH_DSKIP;
              skip_d  = FIELD_W'(b);
            end
          end
          PH_DSKIP, PH_FSKIP, PH_OSKIP: begin
            fc_d = fc_inc;
            if (fc_inc >= skip_q) begin
              fc_d   = '0;
              acc_d  = '0;
              stop_d = 1'b0;
              if (phase_q == PH_DSKIP)      phase_d = PH_FLEN;
              else if (phase_q == PH_FSKIP) phase_d = PH_OLEN;
              else                          phase_d = PH_SEQ;
            end
          end
          PH_FLEN, PH_OLEN: begin
            acc_d  = acc_dig;
            stop_d = stop_dig;
            fc_d   = fc_inc;
            if ((phase_q == PH_FLEN && fc_inc == FIELD_W'(FLEN_DIGITS)) ||
                (phase_q == PH_OLEN && fc_inc == FIELD_W'(OLEN_DIGITS))) begin
              fc_d = '0;
              if (acc_dig[FIELD_W-1:0] == '0) begin
                phase_d = (phase_q == PH_FLEN) ? PH_OLEN : PH_SEQ;
                acc_d   = '0;
                stop_d  = 1'b0;
              end else begin
                phase_d = (phase_q == PH_FLEN) ? PH_FSKIP : PH_OSKIP;
                skip_d  = acc_dig[FIELD_W-1:0];
              end
            end
          end
          PH_SEQ: begin
            acc_d  = acc_dig;
            stop_d = stop_dig;
            fc_d   = fc_inc;
            if (fc_inc == FIELD_W'(SEQ_DIGITS)) begin
              seq_d   = acc_dig[SEQ_W-1:0];
              phase_d = PH_PSIZE;
              fc_d    = '0;
              acc_d   = '0;
              stop_d  = 1'b0;
            end
          end
          PH_PSIZE: begin
            fc_d = fc_inc;
            if (fc_inc == FIELD_W'(PSIZE_DIGITS)) begin
              phase_d = PH_TOTAL;
              fc_d    = '0;
              acc_d   = '0;
              stop_d  = 1'b0;
            end
          end
          PH_TOTAL, PH_CUR: begin
            acc_d  = acc_dig;
            stop_d = stop_dig;
            fc_d   = fc_inc;
            if (fc_inc == FIELD_W'(TOTAL_DIGITS) && phase_q == PH_TOTAL) begin
              total_d = acc_dig[SEG_W-1:0];
              phase_d = PH_CUR;
              fc_d    = '0;
              acc_d   = '0;
              stop_d  = 1'b0;
            end else if (fc_inc == FIELD_W'(CUR_DIGITS) && phase_q == PH_CUR) begin
              cur_d   = acc_dig[SEG_W-1:0];
              phase_d = PH_BODY;
              fill_d  = '0;
            end
          end
          PH_BODY: begin
            if (fill_q >= FILL_W'(TRAIL_DEPTH)) begin
              // Window full: the oldest byte leaves as payload.
              pay_valid = 1'b1;
              for (int i = 0; i < TRAIL_DEPTH - 1; i++) begin
                trail_d[i] = trail_q[i+1];
              end
              trail_d[TRAIL_DEPTH-1] = b;
              sum_d = sum_q + SUM_W'(trail_q[0]);
              if (pcnt_q != {PCNT_W{1'b1}}) pcnt_d = pcnt_q + PCNT_W'(1);
            end else begin
              trail_d[fill_q[FILL_W-1:0]] = b;
              fill_d = fill_q + FILL_W'(1);
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // The summary is built from the state after this byte.
    push_cmd_o.has_payload = pay_valid;
    push_cmd_o.pay_byte    = pay_byte;
    push_cmd_o.has_summary = accept && eod;
    push_cmd_o.drop        = drop_d;
    push_cmd_o.too_short   = !(phase_d == PH_BODY && fill_d == FILL_W'(TRAIL_DEPTH));
    push_cmd_o.seq         = seq_d;
    push_cmd_o.total       = total_d;
    push_cmd_o.current     = cur_d;
    push_cmd_o.count       = pcnt_d;
    push_cmd_o.sum         = sum_d;
    for (int i = 0; i < TRAIL_DEPTH; i++) begin
      push_cmd_o.window[i] = trail_d[i];
    end
    push_o = pay_valid || (accept && eod);

    if (accept && eod) begin
      phase_d = PH_OPCODE;
      fc_d    = '0;
      skip_d  = '0;
      acc_d   = '0;
      stop_d  = 1'b0;
      seq_d   = '0;
      total_d = '0;
      cur_d   = '0;
      fill_d  = '0;
      sum_d   = '0;
      pcnt_d  = '0;
      drop_d  = 1'b0;
      bcnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      fc_q    <= '0;
      skip_q  <= '0;
      acc_q   <= '0;
      stop_q  <= 1'b0;
      seq_q   <= '0;
      total_q <= '0;
      cur_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      pcnt_q  <= '0;
      drop_q  <= 1'b0;
      bcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fc_q    <= fc_d;
      skip_q  <= skip_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      seq_q   <= seq_d;
      total_q <= total_d;
      cur_q   <= cur_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      pcnt_q  <= pcnt_d;
      drop_q  <= drop_d;
      bcnt_q  <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trail_q <= trail_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(TRAIL_DEPTH))
    else $error("holding window fill past its depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eod) |=> (phase_q == PH_OPCODE && bcnt_q == '0 && !drop_q))
    else $error("parser state not cleared after end of datagram");

endmodule

`default_nettype wire

### hdl/dfr_queue.sv
// Short queue of emitter work between the parser and the result emitter.
`default_nettype none

module dfr_queue import dfr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  push_cmd_i,
  output logic       ready_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output cmd_t       head_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o      = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop)      cnt_d = cnt_q + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("work pushed into a full queue");

endmodule

`default_nettype wire

### hdl/dfr_back.sv
// Result emitter: turns queued work into payload and summary beats, checks the checksum.
`default_nettype none

module dfr_back import dfr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire cmd_t  head_cmd_i,
  output logic       pop_o,
  dfr_out_if.source  out_o
);

  res_t             res_q, res_d;
  logic             valid_q, valid_d;
  logic             pay_done_q, pay_done_d;
  logic             load_en;
  status_e          status;
  logic [16:0]      csum;
  logic             csum_stop;
  logic [7:0]       ch;

  // Checksum digits, converted until the first non-digit.
  always_comb begin
    csum      = '0;
    csum_stop = 1'b0;
    for (int i = 0; i < TRAIL_DEPTH; i++) begin
      ch = head_cmd_i.window[i];
      if (!csum_stop && ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
        csum = 17'((20'(csum) << 3) + (20'(csum) << 1) + 20'(ch - ASCII_ZERO));
      end else begin
        csum_stop = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (head_cmd_i.drop)                     status = ST_NOTFILE;
    else if (head_cmd_i.too_short)                    status = ST_SHORT;
    else if (csum[SUM_W-1:0] == head_cmd_i.sum)       status = ST_OK;
    else                                              status = ST_CHECKSUM;
  end

  assign load_en = !valid_q || out_o.ready;

  always_comb begin
    res_d      = res_q;
    valid_d    = valid_q;
    pay_done_d = pay_done_q;
    pop_o      = 1'b0;
    if (load_en) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        res_d = '0;
        if (head_cmd_i.has_payload && !pay_done_q) begin
          res_d.kind     = KIND_PAYLOAD;
          res_d.out_byte = head_cmd_i.pay_byte;
          res_d.last     = !head_cmd_i.has_summary;
          if (head_cmd_i.has_summary) pay_done_d = 1'b1;
          else                        pop_o      = 1'b1;
        end else begin
          res_d.kind           = KIND_SUMMARY;
          res_d.seq_number     = head_cmd_i.seq;
          res_d.total_segments = head_cmd_i.total;
          res_d.segment_index  = head_cmd_i.current;
          res_d.payload_bytes  = head_cmd_i.count;
          res_d.status         = status;
          res_d.last           = 1'b1;
          pop_o                = 1'b1;
          pay_done_d           = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      pay_done_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      pay_done_q <= pay_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.out_byte       = res_q.out_byte;
  assign out_o.seq_number     = res_q.seq_number;
  assign out_o.total_segments = res_q.total_segments;
  assign out_o.segment_index  = res_q.segment_index;
  assign out_o.payload_bytes  = res_q.payload_bytes;
  assign out_o.status         = res_q.status;
  assign out_o.last           = res_q.last;

  a_summary_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_o.ready && res_q.kind == KIND_PAYLOAD && !res_q.last)
      |=> (valid_q && res_q.kind == KIND_SUMMARY))
    else $error("payload beat without last not followed by its summary");

  a_split_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_done_q |-> head_valid_i)
    else $error("half-emitted work vanished from the queue");

endmodule

`default_nettype wire

### hdl/segment_packet_deframer_core.sv
// Top level of the segment packet deframer: parser, work queue and result emitter.
//
// Input channel in_i carries one datagram byte per beat with an end flag on the
// final byte. The first byte must be 'F'; otherwise the datagram is dropped and
// only a summary with status "not file packet" comes out. After the header, every
// byte passes a 5-byte holding window; bytes leaving it go out as payload beats
// (kind 0). On the end flag a summary beat (kind 1) carries the sequence number,
// segment counts, payload count and status; last marks the final beat of a byte.
// Throughput: one input byte per cycle while the queue has room. A byte that yields
// both a payload beat and a summary sends the payload beat first and the summary
// after it. With nothing waiting ahead of it, the first result of a byte passes
// through the queue and then the output register (the parser writes the queue at
// the accepting edge, the output register then loads from the queue).
// When the receiver stalls, the output register holds its beat, the two-entry
// queue fills and in_i.ready falls until a slot frees up.
// Reset clears the parser to wait for an opcode byte and empties the queue and
// the output register; no clearing pass is needed.
`default_nettype none

module segment_packet_deframer_core import dfr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfr_in_if.sink     in_i,
  dfr_out_if.source  out_o
);

  logic push;
  cmd_t push_cmd;
  logic push_ready;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  dfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  dfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .ready_o      (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  dfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
